// ===== sv/bss_pkg.sv =====
`default_nettype none

package bss_pkg;

  // Operation codes of a request
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpBemf  = 2'd1;
  localparam logic [1:0] OpStart = 2'd2;
  localparam logic [1:0] OpStop  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] RegPrechargeTicks = 3'd0;
  localparam logic [2:0] RegAlignTicks     = 3'd1;
  localparam logic [2:0] RegAlignCode      = 3'd2;
  localparam logic [2:0] RegAlignDuty      = 3'd3;
  localparam logic [2:0] RegStartDuty      = 3'd4;
  localparam logic [2:0] RegStepTicks      = 3'd5;
  localparam logic [2:0] RegMaxSteps       = 3'd6;
  localparam logic [2:0] RegConfirmCount   = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration reset values
  localparam logic [15:0] PrechargeTicksRst = 16'd50;
  localparam logic [15:0] AlignTicksRst     = 16'd50;
  localparam logic [2:0]  AlignCodeRst      = 3'd5;
  localparam logic [11:0] AlignDutyRst      = 12'd1000;
  localparam logic [11:0] StartDutyRst      = 12'd500;
  localparam logic [15:0] StepTicksRst      = 16'd28;
  localparam logic [15:0] MaxStepsRst       = 16'd200;
  localparam logic [7:0]  ConfirmCountRst   = 8'd3;

  localparam logic [2:0] LastStep = 3'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] bemf_bits;
  } in_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic        drive_enabled;
    logic        low_sides_on;
    logic [2:0]  commutation_code;
    logic        commutation_strobe;
    logic [11:0] duty;
    logic        started;
  } out_t;

  // Expected back-EMF pattern of each open-loop step; unused indexes read as 5
  function automatic logic [2:0] bemf_expect(input logic [2:0] idx);
    logic [2:0] v;
    unique case (idx)
      3'd0:    v = 3'h5;
      3'd1:    v = 3'h1;
      3'd2:    v = 3'h3;
      3'd3:    v = 3'h2;
      3'd4:    v = 3'h6;
      3'd5:    v = 3'h4;
      default: v = 3'h5;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bldc_sensorless_startup_sequencer.sv =====
// Sensorless six-step BLDC start sequencer.
// Request channel (in_valid_i / in_ready_o / in_req_i) carries one event per
// request: a time tick, a back-EMF comparator sample, a start or a stop.
// Every accepted request yields exactly one response on out_valid_o /
// out_ready_i / out_rsp_o with the phase, bridge controls, duty and the
// started flag as they stand after that request.
// Responses are registered. Requests are taken one per cycle while in_ready_o
// is high; the sequencer state updates in the same edge that accepts the
// request, so the next request sees it immediately.
// The output register is backed by a one-entry skid register, so one more
// request is taken while a response waits; in_ready_o drops only when both
// are full and returns as soon as the receiver takes a response.
// Reset: phase idle, outputs off, counters cleared, configuration back to
// defaults, no response pending. Configuration writes (cfg_we_i) take effect
// at once and must only be issued while the sequencer has no request in
// flight.
`default_nettype none

module bldc_sensorless_startup_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bss_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bss_pkg::in_t                  in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bss_pkg::out_t                      out_rsp_o
);

  typedef enum logic [2:0] {
    PhIdle      = 3'd0,
    PhPrecharge = 3'd1,
    PhAlign     = 3'd2,
    PhOpen      = 3'd3,
    PhRun       = 3'd4,
    PhFault     = 3'd5
  } phase_e;

  // Configuration registers
  logic [15:0] precharge_ticks_q, align_ticks_q, step_ticks_q, max_steps_q;
  logic [2:0]  align_code_q;
  logic [11:0] align_duty_q, start_duty_q;
  logic [7:0]  confirm_count_q;

  // Sequencer state
  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic [2:0]  step_idx_q, step_idx_d;
  logic [15:0] step_total_q, step_total_d;
  logic [7:0]  streak_q, streak_d;
  logic        started_q, started_d;
  logic        drv_en_q, drv_en_d;
  logic        low_on_q, low_on_d;
  logic [2:0]  code_q, code_d;
  logic [11:0] duty_q, duty_d;
  logic        strobe;

  // Response register and skid
  logic          out_valid_q, skid_valid_q;
  bss_pkg::out_t out_q, skid_q, rsp;

  logic        in_fire, out_fire;
  logic [15:0] tick_inc, step_total_inc;
  logic [2:0]  step_idx_next;
  logic [7:0]  streak_new;
  logic        started_new;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Saturating increments shared by the timed phases
  assign tick_inc       = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign step_total_inc = (step_total_q == 16'hFFFF) ? step_total_q : step_total_q + 16'd1;
  assign step_idx_next  = (step_idx_q >= bss_pkg::LastStep) ? 3'd0 : step_idx_q + 3'd1;

  // Streak update for a back-EMF sample while not yet synchronized
  always_comb begin
    if (in_req_i.bemf_bits == bss_pkg::bemf_expect(step_idx_q)) begin
      streak_new = (streak_q == 8'hFF) ? streak_q : streak_q + 8'd1;
    end else begin
      streak_new = 8'd0;
    end
    started_new = started_q || (streak_new >= confirm_count_q);
  end

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    step_idx_d   = step_idx_q;
    step_total_d = step_total_q;
    streak_d     = streak_q;
    started_d    = started_q;
    drv_en_d     = drv_en_q;
    low_on_d     = low_on_q;
    code_d       = code_q;
    duty_d       = duty_q;
    strobe       = 1'b0;
    unique case (in_req_i.operation)
      bss_pkg::OpStart: begin
        // restart precharge; step index carries over to the next open loop
        phase_d      = PhPrecharge;
        tick_d       = 16'd0;
        step_total_d = 16'd0;
        streak_d     = 8'd0;
        started_d    = 1'b0;
        drv_en_d     = 1'b1;
        low_on_d     = 1'b1;
      end
      bss_pkg::OpStop: begin
        phase_d  = PhIdle;
        drv_en_d = 1'b0;
        low_on_d = 1'b0;
      end
      bss_pkg::OpTick: begin
        unique case (phase_q)
          PhPrecharge: begin
            tick_d = tick_inc;
            if (tick_inc >= precharge_ticks_q) begin
              low_on_d = 1'b0;
              code_d   = align_code_q;
              duty_d   = align_duty_q;
              strobe   = 1'b1;
              tick_d   = 16'd0;
              phase_d  = PhAlign;
            end
          end
          PhAlign: begin
            tick_d = tick_inc;
            if (tick_inc >= align_ticks_q) begin
              duty_d     = start_duty_q;
              step_idx_d = step_idx_next;
              code_d     = bss_pkg::bemf_expect(step_idx_next);
              tick_d     = 16'd0;
              strobe     = 1'b1;
              phase_d    = PhOpen;
            end
          end
          PhOpen: begin
            tick_d = tick_inc;
            if (tick_inc >= step_ticks_q) begin
              step_total_d = step_total_inc;
              // step limit wins over a completed sync
              if (step_total_inc >= max_steps_q) begin
                phase_d  = PhFault;
                drv_en_d = 1'b0;
                low_on_d = 1'b0;
              end else if (started_q) begin
                phase_d = PhRun;
              end else begin
                step_idx_d = step_idx_next;
                code_d     = bss_pkg::bemf_expect(step_idx_next);
                tick_d     = 16'd0;
                strobe     = 1'b1;
              end
            end
          end
          default: ;  // idle, run, fault: ticks ignored
        endcase
      end
      default: begin  // back-EMF sample
        if (phase_q == PhOpen || phase_q == PhRun) begin
          if (!started_q) begin
            streak_d  = streak_new;
            started_d = started_new;
          end
          if (started_new) begin
            code_d = in_req_i.bemf_bits;
            strobe = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    rsp.phase              = phase_d;
    rsp.drive_enabled      = drv_en_d;
    rsp.low_sides_on       = low_on_d;
    rsp.commutation_code   = code_d;
    rsp.commutation_strobe = strobe;
    rsp.duty               = duty_d;
    rsp.started            = started_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precharge_ticks_q <= bss_pkg::PrechargeTicksRst;
      align_ticks_q     <= bss_pkg::AlignTicksRst;
      align_code_q      <= bss_pkg::AlignCodeRst;
      align_duty_q      <= bss_pkg::AlignDutyRst;
      start_duty_q      <= bss_pkg::StartDutyRst;
      step_ticks_q      <= bss_pkg::StepTicksRst;
      max_steps_q       <= bss_pkg::MaxStepsRst;
      confirm_count_q   <= bss_pkg::ConfirmCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bss_pkg::RegPrechargeTicks: precharge_ticks_q <= cfg_wdata_i;
        bss_pkg::RegAlignTicks:     align_ticks_q     <= cfg_wdata_i;
        bss_pkg::RegAlignCode:      align_code_q      <= cfg_wdata_i[2:0];
        bss_pkg::RegAlignDuty:      align_duty_q      <= cfg_wdata_i[11:0];
        bss_pkg::RegStartDuty:      start_duty_q      <= cfg_wdata_i[11:0];
        bss_pkg::RegStepTicks:      step_ticks_q      <= cfg_wdata_i;
        bss_pkg::RegMaxSteps:       max_steps_q       <= cfg_wdata_i;
        default:                    confirm_count_q   <= cfg_wdata_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      tick_q       <= 16'd0;
      step_idx_q   <= 3'd0;
      step_total_q <= 16'd0;
      streak_q     <= 8'd0;
      started_q    <= 1'b0;
      drv_en_q     <= 1'b0;
      low_on_q     <= 1'b0;
      code_q       <= 3'd0;
      duty_q       <= 12'd0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      step_idx_q   <= step_idx_d;
      step_total_q <= step_total_d;
      streak_q     <= streak_d;
      started_q    <= started_d;
      drv_en_q     <= drv_en_d;
      low_on_q     <= low_on_d;
      code_q       <= code_d;
      duty_q       <= duty_d;
    end
  end

  // Response register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= rsp;
      end else begin
        out_q <= rsp;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/bldc_sensorless_startup_sequencer_checker.sv =====
`timescale 1ns / 100ps

module bldc_sensorless_startup_sequencer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bss_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  bss_pkg::in_t                 in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  bss_pkg::out_t                out_rsp_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam logic [2:0] PhIdle      = 3'd0;
  localparam logic [2:0] PhPrecharge = 3'd1;
  localparam logic [2:0] PhAlign     = 3'd2;
  localparam logic [2:0] PhOpenLoop  = 3'd3;
  localparam logic [2:0] PhRun       = 3'd4;
  localparam logic [2:0] PhFault     = 3'd5;

  // comparator levels expected at open-loop steps 0..5
  localparam logic [5:0][2:0] StepPattern = {3'h4, 3'h6, 3'h2, 3'h3, 3'h1, 3'h5};

  logic [15:0] cfg_precharge, cfg_align, cfg_step, cfg_max_steps;
  logic [2:0]  cfg_align_code;
  logic [11:0] cfg_align_duty, cfg_start_duty;
  logic [7:0]  cfg_confirm;

  logic [2:0]  seq_phase, step_idx, code_q;
  logic [15:0] tick_cnt, steps_done;
  logic [7:0]  match_run;
  logic        synced, drive_on, low_on;
  logic [11:0] duty_q;

  bss_pkg::out_t status_q[$];

  function automatic logic [15:0] bump_tick();
    if (tick_cnt != 16'hFFFF) tick_cnt++;
    return tick_cnt;
  endfunction

  function automatic void next_step();
    step_idx = (step_idx >= bss_pkg::LastStep) ? 3'd0 : step_idx + 3'd1;
    code_q   = StepPattern[step_idx];
    tick_cnt = '0;
  endfunction

  function automatic bss_pkg::out_t advance_sequencer(bss_pkg::in_t req);
    bss_pkg::out_t rsp;
    logic strobe;
    strobe = 1'b0;
    case (req.operation)
      bss_pkg::OpStart: begin
        seq_phase  = PhPrecharge;
        tick_cnt   = '0;
        steps_done = '0;
        match_run  = '0;
        synced     = 1'b0;
        drive_on   = 1'b1;
        low_on     = 1'b1;
      end
      bss_pkg::OpStop: begin
        seq_phase = PhIdle;
        drive_on  = 1'b0;
        low_on    = 1'b0;
      end
      bss_pkg::OpTick: begin
        if (seq_phase == PhPrecharge) begin
          if (bump_tick() >= cfg_precharge) begin
            low_on    = 1'b0;
            code_q    = cfg_align_code;
            duty_q    = cfg_align_duty;
            strobe    = 1'b1;
            tick_cnt  = '0;
            seq_phase = PhAlign;
          end
        end else if (seq_phase == PhAlign) begin
          if (bump_tick() >= cfg_align) begin
            duty_q = cfg_start_duty;
            next_step();
            strobe    = 1'b1;
            seq_phase = PhOpenLoop;
          end
        end else if (seq_phase == PhOpenLoop) begin
          if (bump_tick() >= cfg_step) begin
            if (steps_done != 16'hFFFF) steps_done++;
            // step budget exhausted wins even over a completed sync
            if (steps_done >= cfg_max_steps) begin
              seq_phase = PhFault;
              drive_on  = 1'b0;
              low_on    = 1'b0;
            end else if (synced) begin
              seq_phase = PhRun;
            end else begin
              next_step();
              strobe = 1'b1;
            end
          end
        end
      end
      bss_pkg::OpBemf: begin
        if (seq_phase == PhOpenLoop || seq_phase == PhRun) begin
          if (!synced) begin
            if (req.bemf_bits == StepPattern[step_idx]) begin
              if (match_run != 8'hFF) match_run++;
            end else begin
              match_run = '0;
            end
            if (match_run >= cfg_confirm) synced = 1'b1;
          end
          // once synced, the sample itself is the commutation pattern
          if (synced) begin
            code_q = req.bemf_bits;
            strobe = 1'b1;
          end
        end
      end
    endcase
    rsp.phase              = seq_phase;
    rsp.drive_enabled      = drive_on;
    rsp.low_sides_on       = low_on;
    rsp.commutation_code   = code_q;
    rsp.commutation_strobe = strobe;
    rsp.duty               = duty_q;
    rsp.started            = synced;
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bss_pkg::out_t want;
    if (!rst_ni) begin
      cfg_precharge  = bss_pkg::PrechargeTicksRst;
      cfg_align      = bss_pkg::AlignTicksRst;
      cfg_align_code = bss_pkg::AlignCodeRst;
      cfg_align_duty = bss_pkg::AlignDutyRst;
      cfg_start_duty = bss_pkg::StartDutyRst;
      cfg_step       = bss_pkg::StepTicksRst;
      cfg_max_steps  = bss_pkg::MaxStepsRst;
      cfg_confirm    = bss_pkg::ConfirmCountRst;
      seq_phase      = PhIdle;
      tick_cnt       = '0;
      step_idx       = '0;
      steps_done     = '0;
      match_run      = '0;
      synced         = 1'b0;
      drive_on       = 1'b0;
      low_on         = 1'b0;
      code_q         = '0;
      duty_q         = '0;
      status_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bss_pkg::RegPrechargeTicks: cfg_precharge  = cfg_wdata_i;
          bss_pkg::RegAlignTicks:     cfg_align      = cfg_wdata_i;
          bss_pkg::RegAlignCode:      cfg_align_code = cfg_wdata_i[2:0];
          bss_pkg::RegAlignDuty:      cfg_align_duty = cfg_wdata_i[11:0];
          bss_pkg::RegStartDuty:      cfg_start_duty = cfg_wdata_i[11:0];
          bss_pkg::RegStepTicks:      cfg_step       = cfg_wdata_i;
          bss_pkg::RegMaxSteps:       cfg_max_steps  = cfg_wdata_i;
          bss_pkg::RegConfirmCount:   cfg_confirm    = cfg_wdata_i[7:0];
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          $error("response arrived with no request outstanding");
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("phase", 12'(want.phase), 12'(out_rsp_i.phase));
          check_field("drive_enabled", 12'(want.drive_enabled),
                      12'(out_rsp_i.drive_enabled));
          check_field("low_sides_on", 12'(want.low_sides_on),
                      12'(out_rsp_i.low_sides_on));
          check_field("commutation_code", 12'(want.commutation_code),
                      12'(out_rsp_i.commutation_code));
          check_field("commutation_strobe", 12'(want.commutation_strobe),
                      12'(out_rsp_i.commutation_strobe));
          check_field("duty", want.duty, out_rsp_i.duty);
          check_field("started", 12'(want.started), 12'(out_rsp_i.started));
        end
      end
      if (in_valid_i && in_ready_i) status_q.push_back(advance_sequencer(in_req_i));
      pending_o = status_q.size();
    end
  end

endmodule

// ===== tb/sv/bldc_sensorless_startup_sequencer_tb.sv =====
`timescale 1ns / 100ps

module bldc_sensorless_startup_sequencer_tb;

  // Ticks sent per timed phase are capped so that huge limits only get a taste
  localparam int unsigned TickCap = 56;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [bss_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bss_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  bss_pkg::in_t                 in_req_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  bss_pkg::out_t                out_rsp_o;

  int unsigned fail_count, pending;

  // Sender bookkeeping
  int unsigned items_sent = 0;
  int unsigned phase_end = 0;
  int unsigned send_run_left = 0;
  bit          send_calm = 1'b0;

  // Register values last written; used only to shape the request sequences
  int unsigned set_pre, set_align, set_step, set_max, set_confirm;

  always #2 clk_i = ~clk_i;

  bldc_sensorless_startup_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  bldc_sensorless_startup_sequencer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offer one request and hold it until the sequencer takes it. Entered and
  // left at a falling edge; valid stays up so back-to-back requests stream.
  // Gaps come in stretches: some runs have none, others mostly short ones
  // with the odd long pause.
  task automatic push_request(input logic [1:0] op, input logic [2:0] bemf);
    int unsigned gap, r;
    if (send_run_left == 0) begin
      send_calm     = ($urandom_range(0, 2) == 0);
      send_run_left = $urandom_range(20, 100);
    end
    send_run_left--;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!send_calm && r >= 60) gap = (r >= 94) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{operation: op, bemf_bits: bemf};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic put_reg(input logic [bss_pkg::CfgIdxW-1:0] idx,
                         input logic [bss_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // Full register set, back to back; only called with nothing in flight
  task automatic write_settings(input int unsigned pre, align, code, aduty, sduty,
                                input int unsigned step, maxs, confirm);
    put_reg(bss_pkg::RegPrechargeTicks, 16'(pre));
    put_reg(bss_pkg::RegAlignTicks, 16'(align));
    put_reg(bss_pkg::RegAlignCode, 16'(code));
    put_reg(bss_pkg::RegAlignDuty, 16'(aduty));
    put_reg(bss_pkg::RegStartDuty, 16'(sduty));
    put_reg(bss_pkg::RegStepTicks, 16'(step));
    put_reg(bss_pkg::RegMaxSteps, 16'(maxs));
    put_reg(bss_pkg::RegConfirmCount, 16'(confirm));
    cfg_we_i    <= 1'b0;
    set_pre     = pre;
    set_align   = align;
    set_step    = step;
    set_max     = maxs;
    set_confirm = confirm;
  endtask

  // Stop offering, let every response drain, then let the bench sit quiet
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic int unsigned ticks_for(input int unsigned limit);
    if (limit == 0) return 1;
    return (limit > TickCap) ? TickCap : limit;
  endfunction

  // Ticks, now and then preceded by a stray sample or a fully random request
  task automatic run_ticks(input int unsigned n);
    int unsigned left, r;
    left = n;
    while (left > 0 && items_sent < phase_end) begin
      r = $urandom_range(0, 99);
      if (r < 8) push_request(bss_pkg::OpBemf, 3'($urandom_range(0, 7)));
      else if (r < 10) push_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      push_request(bss_pkg::OpTick, 3'($urandom_range(0, 7)));
      left--;
    end
  endtask

  // Sweep all six table patterns in rotation, each repeated; whichever one
  // the current step expects builds the streak without any tick in between.
  task automatic sync_burst(input int unsigned copies);
    int unsigned v;
    bit down;
    v    = $urandom_range(1, 6);
    down = ($urandom_range(0, 1) == 1);
    repeat (6) begin
      repeat (copies) push_request(bss_pkg::OpBemf, 3'(v));
      if (down) v = (v == 1) ? 6 : v - 1;
      else v = (v == 6) ? 1 : v + 1;
    end
  endtask

  // One start attempt: precharge, align, a number of open-loop steps with
  // sync bursts or noise, some run-time traffic, and maybe a stop.
  task automatic start_attempt();
    int unsigned steps, copies;
    push_request(bss_pkg::OpStart, 3'($urandom_range(0, 7)));
    run_ticks(ticks_for(set_pre));
    run_ticks(ticks_for(set_align));
    steps = $urandom_range(1, ((set_max > 12) ? 12 : set_max) + 2);
    for (int s = 0; s < steps && items_sent < phase_end; s++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          copies = (set_confirm > 4) ? 4 : set_confirm;
          if ($urandom_range(0, 4) == 0) copies = $urandom_range(1, copies);
          sync_burst(copies);
        end
        2: repeat ($urandom_range(1, 4))
             push_request(bss_pkg::OpBemf, 3'($urandom_range(0, 7)));
        default: ;
      endcase
      run_ticks(ticks_for(set_step));
    end
    repeat ($urandom_range(0, 10))
      push_request($urandom_range(0, 1) ? bss_pkg::OpTick : bss_pkg::OpBemf,
                   3'($urandom_range(0, 7)));
    if ($urandom_range(0, 2) == 0) push_request(bss_pkg::OpStop, 3'($urandom_range(0, 7)));
  endtask

  // Receiver: stretches with no stalls and stretches of random stalls; every
  // few hundred responses it also refuses for a long spell so the skid
  // buffer fills and the request side backs up.
  initial begin : receiver
    int unsigned hold_left, rsp_seen, next_hold_at, run_left, r;
    bit calm;
    hold_left    = 0;
    rsp_seen     = 0;
    next_hold_at = 300;
    run_left     = 0;
    calm         = 1'b0;
    out_ready_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) rsp_seen++;
      @(negedge clk_i);
      if (rsp_seen >= next_hold_at) begin
        hold_left    = 250;
        next_hold_at = next_hold_at + 600;
      end
      if (run_left == 0) begin
        calm     = ($urandom_range(0, 2) == 0);
        run_left = $urandom_range(20, 100);
      end
      run_left--;
      if (hold_left == 0 && !calm) begin
        r = $urandom_range(0, 99);
        if (r < 25) hold_left = (r < 3) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    set_pre     = bss_pkg::PrechargeTicksRst;
    set_align   = bss_pkg::AlignTicksRst;
    set_step    = bss_pkg::StepTicksRst;
    set_max     = bss_pkg::MaxStepsRst;
    set_confirm = bss_pkg::ConfirmCountRst;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: tick, sample and stop while idle, then a start that is
    // stopped in precharge (a sample there is ignored).
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpBemf, 3'd7);
    push_request(bss_pkg::OpStop, 3'd0);
    push_request(bss_pkg::OpStart, 3'd0);
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpBemf, 3'd2);
    push_request(bss_pkg::OpStop, 3'd0);
    wait_quiet();

    // Zero precharge leaves on the first tick; align of one tick likewise.
    // Align pattern and duty at their top values, start duty at zero.
    write_settings(0, 1, 7, 4095, 0, 1, 4, 1);
    push_request(bss_pkg::OpStart, 3'd0);
    push_request(bss_pkg::OpTick, 3'd0);   // into align
    push_request(bss_pkg::OpTick, 3'd0);   // into open loop, step 1
    push_request(bss_pkg::OpBemf, 3'd1);   // matches step 1, single-sample sync
    push_request(bss_pkg::OpBemf, 3'd6);   // synced: sample drives the bridge
    push_request(bss_pkg::OpTick, 3'd0);   // step end with sync -> run
    push_request(bss_pkg::OpTick, 3'd0);   // no effect in run
    push_request(bss_pkg::OpBemf, 3'd3);
    push_request(bss_pkg::OpStart, 3'd0);  // restart from run, table index kept
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpBemf, 3'd0);   // mismatch
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpTick, 3'd0);
    push_request(bss_pkg::OpTick, 3'd0);   // step budget used up -> fault
    push_request(bss_pkg::OpTick, 3'd0);   // no effect in fault
    push_request(bss_pkg::OpBemf, 3'd4);   // ignored in fault
    push_request(bss_pkg::OpStop, 3'd0);

    // Random phases, each under its own register set
    for (int ph = 1; ph <= 9; ph++) begin
      wait_quiet();
      case (ph)
        2: begin
          // every register at its top value
          write_settings(16'hFFFF, 16'hFFFF, 7, 4095, 4095, 16'hFFFF, 16'hFFFF, 255);
          phase_end = items_sent + 60;
        end
        3: begin
          // shortest everything: each open-loop step end faults at once
          write_settings(0, 0, 0, 0, 0, 1, 1, 1);
          phase_end = items_sent + 120;
        end
        4: begin
          // long open loop where sync can never be reached
          write_settings(0, 0, $urandom_range(0, 7), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), 16'hFFFF, 16'hFFFF, 255);
          phase_end = items_sent + 80;
        end
        5: begin
          write_settings(bss_pkg::PrechargeTicksRst, bss_pkg::AlignTicksRst,
                         bss_pkg::AlignCodeRst, bss_pkg::AlignDutyRst,
                         bss_pkg::StartDutyRst, bss_pkg::StepTicksRst,
                         bss_pkg::MaxStepsRst, bss_pkg::ConfirmCountRst);
          phase_end = items_sent + 300;
        end
        default: begin
          write_settings($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 7),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(1, 5), $urandom_range(1, 10), $urandom_range(1, 4));
          phase_end = items_sent + 210;
        end
      endcase
      while (items_sent < phase_end) start_attempt();
    end

    wait_quiet();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bldc_sensorless_startup_sequencer_tb passed");
    end else begin
      $display("bldc_sensorless_startup_sequencer_tb failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("bldc_sensorless_startup_sequencer_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bss_pkg.sv
sv/bldc_sensorless_startup_sequencer.sv
tb/sv/bldc_sensorless_startup_sequencer_checker.sv
tb/sv/bldc_sensorless_startup_sequencer_tb.sv
